FILE: rtl/cua_pkg.sv
// ----------------------------------------------------------------------------
// cua_pkg
// shared types and constants of the contiguous unit allocator
// ----------------------------------------------------------------------------
package cua_pkg;

  localparam int unsigned SMALL_RUN_LIMIT = 2;

  typedef enum logic [1:0] {
    STATUS_OK     = 2'd0,
    STATUS_DENIED = 2'd1,
    STATUS_NONE   = 2'd2
  } status_t;

  typedef enum logic {
    ACT_ALLOC = 1'b0,
    ACT_FREE  = 1'b1
  } action_t;

  typedef enum logic {
    FIT_FIRST = 1'b0,
    FIT_BEST  = 1'b1
  } fit_t;

  typedef enum logic [0:0] {
    REG_FIT_MODE = 1'b0
  } reg_idx_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_SRCH,
    ST_FILL,
    ST_FREE,
    ST_CNT,
    ST_DONE
  } state_t;

endpackage

FILE: rtl/cua_if.sv
// ----------------------------------------------------------------------------
// cua_in_if / cua_out_if
// valid/ready channels of the allocator
// ----------------------------------------------------------------------------
interface cua_in_if;
  logic        valid;
  logic        ready;
  logic        action;
  logic [15:0] owner_id;
  logic [8:0]  unit_count;
  modport source (output valid, action, owner_id, unit_count, input ready);
  modport sink   (input valid, action, owner_id, unit_count, output ready);
endinterface

interface cua_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] status;
  logic [7:0] start_unit;
  logic [7:0] runs_visited;
  logic [7:0] small_fragments;
  modport source (output valid, status, start_unit, runs_visited, small_fragments,
                  input ready);
  modport sink   (input valid, status, start_unit, runs_visited, small_fragments,
                  output ready);
endinterface

FILE: rtl/cua_ram.sv
// ----------------------------------------------------------------------------
// cua_ram
// generic single port ram with registered read
// ----------------------------------------------------------------------------
module cua_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule

FILE: rtl/contiguous_unit_allocator.sv
// ----------------------------------------------------------------------------
// contiguous_unit_allocator
// hands out contiguous runs of a unit pool to process ids
// ----------------------------------------------------------------------------
// Each unit is one ram word {busy, owner}. A request is processed one unit per
// cycle, apart from the write-backs of a free, by a read-modify-write sequencer
// on that ram: an allocate of nonzero size scans the map for a run, then writes
// the granted units; a free sweeps all units, pausing the sweep to write back
// each unit it releases; every request ends with a sweep that counts small free
// runs. The result is then held until it is taken. After reset a clearing pass
// marks every unit free before the first word is taken.
module contiguous_unit_allocator #(
  parameter int MEMORY_UNITS = 256,
  parameter int ID_BITS      = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  cua_in_if.sink      in_ch,
  cua_out_if.source   out_ch,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  localparam int AW = $clog2(MEMORY_UNITS);
  localparam int CW = AW + 1;
  localparam int W  = ID_BITS + 1;

  cua_pkg::state_t st_r, st_nxt;
  logic fit_r;
  logic [CW-1:0] idx_r, idx_nxt;         // address of the unit being presented
  logic          rv_r, rv_nxt;           // read data valid for unit rd_r
  logic [CW-1:0] rd_r, rd_nxt;
  logic [ID_BITS-1:0] pid_r;
  logic [8:0]    want_r;
  logic [CW-1:0] run_s_r, run_s_nxt, run_l_r, run_l_nxt;
  logic          found_r, found_nxt;
  logic [CW-1:0] best_s_r, best_s_nxt, best_l_r, best_l_nxt;
  logic [CW-1:0] vis_r, vis_nxt;
  logic [CW-1:0] sml_r, sml_nxt;
  logic          any_r, any_nxt;
  logic [1:0]    stat_r, stat_nxt;
  logic [7:0]    start_r, start_nxt;
  logic          ov_r, ov_nxt;

  logic          we;
  logic [AW-1:0] addr;
  logic [W-1:0]  wdata, rdata;
  logic          busy;

  cua_ram #(.WIDTH(W), .DEPTH(MEMORY_UNITS)) u_ram (
    .clk(clk), .we(we), .addr(addr), .wdata(wdata), .rdata(rdata)
  );

  assign busy = rdata[W-1];
  assign cfg_pready = 1'b1;
  assign cfg_prdata = {31'd0, fit_r};
  assign in_ch.ready = (st_r == cua_pkg::ST_IDLE) && !ov_r;
  assign out_ch.valid = ov_r;
  assign out_ch.status = stat_r;
  assign out_ch.start_unit = start_r;
  assign out_ch.runs_visited = (vis_r > CW'(255)) ? 8'hff : 8'(vis_r);
  assign out_ch.small_fragments = (sml_r > CW'(255)) ? 8'hff : 8'(sml_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fit_r <= 1'b0;
    end else if (cfg_psel && cfg_penable && cfg_pwrite &&
                 cfg_paddr[2] == cua_pkg::REG_FIT_MODE && cfg_paddr[1:0] == 2'd0) begin
      fit_r <= cfg_pwdata[0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= cua_pkg::ST_CLEAR;
      idx_r <= '0;
      rv_r <= 1'b0;
      ov_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      idx_r <= idx_nxt;
      rv_r <= rv_nxt;
      ov_r <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rd_r <= rd_nxt;
    run_s_r <= run_s_nxt;
    run_l_r <= run_l_nxt;
    found_r <= found_nxt;
    best_s_r <= best_s_nxt;
    best_l_r <= best_l_nxt;
    vis_r <= vis_nxt;
    sml_r <= sml_nxt;
    any_r <= any_nxt;
    stat_r <= stat_nxt;
    start_r <= start_nxt;
    if (in_ch.valid && in_ch.ready) begin
      pid_r <= ID_BITS'(in_ch.owner_id);
      want_r <= in_ch.unit_count;
    end
  end

  // run closes at unit rd_r when it is busy, or after the last unit
  logic          run_end;
  logic [CW-1:0] len_c;
  logic [CW-1:0] want_c;
  logic [9+CW-1:0] want_x;
  assign want_x = {{CW{1'b0}}, want_r};
  assign want_c = (want_x > (9+CW)'(MEMORY_UNITS)) ? CW'(MEMORY_UNITS) + 1'b1 :
                  want_x[CW-1:0];

  always_comb begin
    st_nxt = st_r;
    idx_nxt = idx_r;
    rv_nxt = 1'b0;
    rd_nxt = idx_r;
    run_s_nxt = run_s_r;
    run_l_nxt = run_l_r;
    found_nxt = found_r;
    best_s_nxt = best_s_r;
    best_l_nxt = best_l_r;
    vis_nxt = vis_r;
    sml_nxt = sml_r;
    any_nxt = any_r;
    stat_nxt = stat_r;
    start_nxt = start_r;
    ov_nxt = ov_r && !out_ch.ready;
    we = 1'b0;
    addr = idx_r[AW-1:0];
    wdata = '0;
    run_end = 1'b0;
    len_c = run_l_r;
    case (st_r)
      cua_pkg::ST_CLEAR: begin
        we = 1'b1;
        idx_nxt = idx_r + 1'b1;
        if (idx_r == CW'(MEMORY_UNITS - 1)) begin
          st_nxt = cua_pkg::ST_IDLE;
        end
      end
      cua_pkg::ST_IDLE: begin
        if (in_ch.valid && in_ch.ready) begin
          idx_nxt = '0;
          run_l_nxt = '0;
          found_nxt = 1'b0;
          best_l_nxt = '0;
          best_s_nxt = '0;
          vis_nxt = '0;
          any_nxt = 1'b0;
          stat_nxt = cua_pkg::STATUS_OK;
          start_nxt = '0;
          if (in_ch.action == cua_pkg::ACT_FREE) begin
            st_nxt = cua_pkg::ST_FREE;
          end else if (in_ch.unit_count == 9'd0) begin
            stat_nxt = cua_pkg::STATUS_DENIED;
            st_nxt = cua_pkg::ST_CNT;
          end else begin
            st_nxt = cua_pkg::ST_SRCH;
          end
        end
      end
      cua_pkg::ST_SRCH: begin
        // issue reads through MEMORY_UNITS-1, evaluate each read in the next cycle
        if (idx_r < CW'(MEMORY_UNITS)) begin
          rv_nxt = 1'b1;
          idx_nxt = idx_r + 1'b1;
        end
        if (rv_r) begin
          if (!busy) begin
            if (run_l_r == '0) run_s_nxt = rd_r;
            run_l_nxt = run_l_r + 1'b1;
          end
          run_end = (busy || rd_r == CW'(MEMORY_UNITS - 1)) && (run_l_nxt != '0);
          len_c = run_l_nxt;
          if (busy) run_l_nxt = '0;
          if (run_end) begin
            vis_nxt = vis_r + 1'b1;
            run_l_nxt = '0;
            if (fit_r == cua_pkg::FIT_FIRST) begin
              if (len_c >= want_c) begin
                found_nxt = 1'b1;
                best_s_nxt = (run_l_r == '0) ? rd_r : run_s_r;
                st_nxt = cua_pkg::ST_FILL;
              end
            end else if (len_c == want_c) begin
              found_nxt = 1'b1;
              best_s_nxt = (run_l_r == '0) ? rd_r : run_s_r;
              st_nxt = cua_pkg::ST_FILL;
            end else if (len_c > want_c && (!found_r || len_c < best_l_r)) begin
              found_nxt = 1'b1;
              best_s_nxt = (run_l_r == '0) ? rd_r : run_s_r;
              best_l_nxt = len_c;
            end
          end
          if (rd_r == CW'(MEMORY_UNITS - 1) && st_nxt == cua_pkg::ST_SRCH) begin
            st_nxt = found_nxt ? cua_pkg::ST_FILL : cua_pkg::ST_CNT;
            if (!found_nxt) begin
              stat_nxt = cua_pkg::STATUS_DENIED;
              idx_nxt = '0;
            end
          end
        end
        if (st_nxt == cua_pkg::ST_FILL) begin
          idx_nxt = best_s_nxt;
          run_l_nxt = '0;
          start_nxt = 8'(best_s_nxt);
        end
      end
      cua_pkg::ST_FILL: begin
        we = 1'b1;
        wdata = {1'b1, pid_r};
        idx_nxt = idx_r + 1'b1;
        run_l_nxt = run_l_r + 1'b1;
        if (run_l_nxt == want_c || idx_r == CW'(MEMORY_UNITS - 1)) begin
          st_nxt = cua_pkg::ST_CNT;
          idx_nxt = '0;
          run_l_nxt = '0;
        end
      end
      cua_pkg::ST_FREE: begin
        // read at idx, write back the unit read last cycle
        if (rv_r && busy && rdata[ID_BITS-1:0] == pid_r) begin
          we = 1'b1;
          addr = rd_r[AW-1:0];
          any_nxt = 1'b1;
        end else if (idx_r < CW'(MEMORY_UNITS)) begin
          rv_nxt = 1'b1;
          idx_nxt = idx_r + 1'b1;
        end
        if (rv_r && rd_r == CW'(MEMORY_UNITS - 1) && !rv_nxt) begin
          st_nxt = cua_pkg::ST_CNT;
          idx_nxt = '0;
          run_l_nxt = '0;
          if (!any_nxt) stat_nxt = cua_pkg::STATUS_NONE;
        end else if (we) begin
          rd_nxt = rd_r;
        end
      end
      cua_pkg::ST_CNT: begin
        if (idx_r < CW'(MEMORY_UNITS)) begin
          rv_nxt = 1'b1;
          idx_nxt = idx_r + 1'b1;
        end
        if (idx_r == '0 && !rv_r) sml_nxt = '0;
        if (rv_r) begin
          run_l_nxt = busy ? '0 : run_l_r + 1'b1;
          len_c = busy ? run_l_r : run_l_r + 1'b1;
          if ((busy || rd_r == CW'(MEMORY_UNITS - 1)) && len_c != '0 &&
              len_c <= CW'(cua_pkg::SMALL_RUN_LIMIT)) begin
            sml_nxt = sml_r + 1'b1;
          end
          if (rd_r == CW'(MEMORY_UNITS - 1)) st_nxt = cua_pkg::ST_DONE;
        end
      end
      cua_pkg::ST_DONE: begin
        if (!ov_r) begin
          ov_nxt = 1'b1;
          st_nxt = cua_pkg::ST_IDLE;
        end
      end
      default: st_nxt = cua_pkg::ST_IDLE;
    endcase
  end

  a_no_take_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r != cua_pkg::ST_IDLE) |-> !in_ch.ready) else $error("ready while busy");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && !out_ch.ready) |=> out_ch.valid) else $error("word dropped");
  a_fill_found: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == cua_pkg::ST_FILL) |-> found_r) else $error("fill without fit");
endmodule

FILE: bench/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// testbench of the contiguous unit allocator: random and directed allocate
// and free requests under both fit modes, checked word by word against an
// allocation map kept in the bench, with idle and stall phases on both sides
// ----------------------------------------------------------------------------
module tb_top;

  localparam int UNITS = 256;

  typedef struct packed {
    logic        action;
    logic [15:0] owner_id;
    logic [8:0]  unit_count;
  } request_t;

  typedef struct packed {
    logic [1:0] status;
    logic [7:0] start_unit;
    logic [7:0] runs_visited;
    logic [7:0] small_fragments;
  } grant_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [2:0]  cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  cua_in_if  in_ch ();
  cua_out_if out_ch ();

  contiguous_unit_allocator i_dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  request_t    pending_reqs[$];
  grant_t      expected_grants[$];
  logic        map_busy[UNITS];
  logic [15:0] map_owner[UNITS];
  cua_pkg::fit_t fit_sel;
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;
  int          hold_cycles = 0;
  int          errors = 0;
  int          granted = 0;
  int          words_seen = 0;
  bit          in_done = 1'b0;
  logic [15:0] live_ids[$];

  function automatic int free_run_len(int s);
    int e;
    e = s;
    while (e < UNITS && !map_busy[e]) e++;
    return e - s;
  endfunction

  function automatic grant_t allocate_predict(request_t r);
    grant_t g;
    int i, len, visited, best_start, best_len, nsmall;
    bit found, any;
    g = '0;
    visited = 0;
    found = 0;
    best_start = 0;
    best_len = 0;
    any = 0;
    if (r.action == cua_pkg::ACT_ALLOC) begin
      if (r.unit_count == 0) begin
        g.status = cua_pkg::STATUS_DENIED;
      end else begin
        i = 0;
        while (i < UNITS) begin
          if (map_busy[i]) begin
            i++;
            continue;
          end
          len = free_run_len(i);
          visited++;
          if (fit_sel == cua_pkg::FIT_FIRST) begin
            if (len >= r.unit_count) begin
              found = 1;
              best_start = i;
              break;
            end
          end else begin
            if (len == r.unit_count) begin
              found = 1;
              best_start = i;
              break;
            end
            if (len > r.unit_count && (!found || len < best_len)) begin
              found = 1;
              best_start = i;
              best_len = len;
            end
          end
          i += len;
        end
        if (found) begin
          for (int k = 0; k < r.unit_count && best_start + k < UNITS; k++) begin
            map_busy[best_start + k] = 1'b1;
            map_owner[best_start + k] = r.owner_id;
          end
          g.status = cua_pkg::STATUS_OK;
          g.start_unit = best_start[7:0];
        end else begin
          g.status = cua_pkg::STATUS_DENIED;
        end
      end
    end else begin
      for (i = 0; i < UNITS; i++) begin
        if (map_busy[i] && map_owner[i] == r.owner_id) begin
          map_busy[i] = 1'b0;
          any = 1;
        end
      end
      g.status = any ? cua_pkg::STATUS_OK : cua_pkg::STATUS_NONE;
    end
    g.runs_visited = visited > 255 ? 8'd255 : visited[7:0];
    nsmall = 0;
    i = 0;
    while (i < UNITS) begin
      if (map_busy[i]) begin
        i++;
      end else begin
        len = free_run_len(i);
        if (len <= cua_pkg::SMALL_RUN_LIMIT) nsmall++;
        i += len;
      end
    end
    g.small_fragments = nsmall > 255 ? 8'd255 : nsmall[7:0];
    return g;
  endfunction

  // driver
  always @(negedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else if (!in_ch.valid || in_done) begin
      in_done = 1'b0;
      if (pending_reqs.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        in_ch.valid      <= 1'b1;
        in_ch.action     <= pending_reqs[0].action;
        in_ch.owner_id   <= pending_reqs[0].owner_id;
        in_ch.unit_count <= pending_reqs[0].unit_count;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // accepted word bookkeeping at the rising edge
  always @(posedge clk) begin
    request_t req_w;
    if (rst_n && in_ch.valid && in_ch.ready) begin
      req_w = pending_reqs.pop_front();
      expected_grants.insert(expected_grants.size(), allocate_predict(req_w));
      in_done = 1'b1;
    end
  end

  // receiver ready
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else if (hold_cycles > 0) begin
      hold_cycles  <= hold_cycles - 1;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // monitor
  always @(posedge clk) begin
    grant_t act, exp_g;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      act = {out_ch.status, out_ch.start_unit, out_ch.runs_visited,
             out_ch.small_fragments};
      words_seen++;
      if (expected_grants.size() == 0) begin
        $display("%0t: unexpected word %h", $time, act);
        errors++;
      end else begin
        exp_g = expected_grants.pop_front();
        if (act.status == cua_pkg::STATUS_OK && exp_g.status == cua_pkg::STATUS_OK)
          granted++;
        if (act.status != exp_g.status)
          $display("%0t: status exp %0d act %0d", $time, exp_g.status, act.status);
        if (act.start_unit != exp_g.start_unit)
          $display("%0t: start_unit exp %0d act %0d", $time, exp_g.start_unit,
                   act.start_unit);
        if (act.runs_visited != exp_g.runs_visited)
          $display("%0t: runs_visited exp %0d act %0d", $time, exp_g.runs_visited,
                   act.runs_visited);
        if (act.small_fragments != exp_g.small_fragments)
          $display("%0t: small_fragments exp %0d act %0d", $time,
                   exp_g.small_fragments, act.small_fragments);
        if (act != exp_g) errors++;
      end
    end
  end

  task automatic wait_drained();
    while (pending_reqs.size() > 0 || expected_grants.size() > 0) @(posedge clk);
    repeat (800) @(posedge clk);
  endtask

  task automatic write_fit(cua_pkg::fit_t m);
    @(negedge clk);
    cfg_psel   <= 1'b1;
    cfg_pwrite <= 1'b1;
    cfg_paddr  <= 3'(4 * cua_pkg::REG_FIT_MODE);
    cfg_pwdata <= {31'd0, m};
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    fit_sel = m;
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
  endtask

  task automatic queue_req(logic act, logic [15:0] id, logic [8:0] cnt);
    request_t r;
    r.action = act;
    r.owner_id = id;
    r.unit_count = cnt;
    pending_reqs.insert(pending_reqs.size(), r);
  endtask

  // mostly small allocations among few ids, with frees to fragment the pool
  task automatic queue_random(int n);
    logic [15:0] id;
    logic [8:0]  cnt;
    for (int k = 0; k < n; k++) begin
      case ($urandom_range(19))
        0: queue_req(cua_pkg::ACT_ALLOC, 16'($urandom), 9'($urandom));
        1: queue_req(cua_pkg::ACT_FREE, 16'($urandom), 9'($urandom));
        2: queue_req(cua_pkg::ACT_ALLOC, 16'($urandom_range(15)),
                     9'($urandom_range(256)));
        3, 4, 5, 6, 7: begin
          id = (live_ids.size() > 0) ? live_ids[$urandom_range(live_ids.size() - 1)]
                                     : 16'($urandom_range(15));
          queue_req(cua_pkg::ACT_FREE, id, 9'($urandom));
        end
        default: begin
          id = $urandom_range(3) == 0 ? 16'($urandom) : 16'($urandom_range(31));
          cnt = $urandom_range(4) == 0 ? 9'($urandom_range(64)) : 9'($urandom_range(6));
          queue_req(cua_pkg::ACT_ALLOC, id, cnt);
          live_ids.insert(live_ids.size(), id);
          if (live_ids.size() > 40) void'(live_ids.pop_front());
        end
      endcase
    end
  endtask

  initial begin
    for (int i = 0; i < UNITS; i++) begin
      map_busy[i] = 1'b0;
      map_owner[i] = '0;
    end
    fit_sel = cua_pkg::FIT_FIRST;
    in_ch.valid = 1'b0;
    in_ch.action = 1'b0;
    in_ch.owner_id = '0;
    in_ch.unit_count = '0;
    out_ch.ready = 1'b0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: extremes, exact fit, no fit, unknown id
    queue_req(cua_pkg::ACT_ALLOC, 16'hffff, 9'd0);
    queue_req(cua_pkg::ACT_ALLOC, 16'h0000, 9'd256);
    queue_req(cua_pkg::ACT_FREE,  16'h0000, 9'h1ff);
    queue_req(cua_pkg::ACT_ALLOC, 16'h0001, 9'd257);
    queue_req(cua_pkg::ACT_ALLOC, 16'h0001, 9'd1);
    queue_req(cua_pkg::ACT_ALLOC, 16'h0002, 9'd2);
    queue_req(cua_pkg::ACT_ALLOC, 16'h0003, 9'd5);
    queue_req(cua_pkg::ACT_ALLOC, 16'h0004, 9'd3);
    queue_req(cua_pkg::ACT_ALLOC, 16'hffff, 9'd1);
    queue_req(cua_pkg::ACT_FREE,  16'h0002, 9'd0);
    queue_req(cua_pkg::ACT_FREE,  16'h0004, 9'd0);
    queue_req(cua_pkg::ACT_FREE,  16'h1234, 9'd0);
    queue_req(cua_pkg::ACT_ALLOC, 16'h0005, 9'd3);
    queue_req(cua_pkg::ACT_ALLOC, 16'h0006, 9'd2);
    queue_req(cua_pkg::ACT_ALLOC, 16'h0007, 9'd511);
    wait_drained();
    write_fit(cua_pkg::FIT_BEST);
    queue_req(cua_pkg::ACT_ALLOC, 16'h0008, 9'd3);
    queue_req(cua_pkg::ACT_FREE,  16'h0003, 9'd0);
    queue_req(cua_pkg::ACT_ALLOC, 16'h0009, 9'd2);
    queue_req(cua_pkg::ACT_ALLOC, 16'h000a, 9'd4);
    queue_req(cua_pkg::ACT_ALLOC, 16'h000b, 9'd240);
    queue_req(cua_pkg::ACT_FREE,  16'hffff, 9'd0);
    wait_drained();

    for (int ph = 0; ph < 8; ph++) begin
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 78; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 78; end
        default: begin send_idle_pct = 25; recv_stall_pct = 25; end
      endcase
      write_fit(ph[0] ? cua_pkg::FIT_FIRST : cua_pkg::FIT_BEST);
      if (ph == 4) begin
        @(negedge clk);
        hold_cycles = 3000;
      end
      queue_random(104);
      wait_drained();
    end
    $display("requests checked: %0d, grants: %0d, both fit modes, four idle phases",
             words_seen, granted);
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #40ms;
    $display("== FAIL ==");
    $finish;
  end

endmodule
